// ----- rtl/core/sfr_pkg.sv -----
package sfr_pkg;

  // Largest payload a frame may carry; the body limit resets to twice this
  // value less four, which leaves room for stuffing and the check byte.
  localparam int MAX_PAYLOAD = 1024;

  localparam int CFG_W = 12;

  localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
  localparam logic [7:0]  ESC_BYTE   = 8'h7D;
  localparam logic [7:0]  ESC_FLAG   = 8'h5E;
  localparam logic [7:0]  ESC_ESC    = 8'h5D;
  localparam logic [7:0]  CTRL_SEQ0  = 8'h00;
  localparam logic [7:0]  CTRL_SEQ1  = 8'h02;
  localparam logic [7:0]  REPLY_RR   = 8'h01;
  localparam logic [7:0]  REPLY_REJ  = 8'h05;
  localparam logic [7:0]  REPLY_R    = 8'h20;
  localparam logic [7:0]  ADDR_RESET = 8'h03;
  localparam logic [11:0] MAXB_RESET = 12'(2 * MAX_PAYLOAD - 4);

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_BAD = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  localparam logic REG_ADDR = 1'b0;
  localparam logic REG_MAXB = 1'b1;

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_ADDR = 3'd1,
    PH_CTRL = 3'd2,
    PH_BCC1 = 3'd3,
    PH_BODY = 3'd4
  } phase_t;

  typedef struct packed {
    logic       out_kind;
    logic [7:0] data_byte;
    logic [1:0] status;
    logic [7:0] reply_control;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } step_t;

  typedef struct packed {
    logic [7:0] held;
    logic [1:0] seen;
    logic [7:0] rxor;
  } body_t;

  typedef struct packed {
    step_t s;
    body_t b;
  } work_t;

  function automatic result_t data_res(input logic [7:0] d);
    result_t r;
    r               = '0;
    r.out_kind      = KIND_DATA;
    r.data_byte     = d;
    return r;
  endfunction

  function automatic result_t status_res(input logic [1:0] st, input logic [7:0] reply);
    result_t r;
    r               = '0;
    r.out_kind      = KIND_STATUS;
    r.status        = st;
    r.reply_control = reply;
    return r;
  endfunction

  function automatic step_t append(input step_t s, input result_t x);
    step_t o;
    o = s;
    if (s.n == 2'd0) begin
      o.r0 = x;
    end else begin
      o.r1 = x;
    end
    o.n = s.n + 2'd1;
    return o;
  endfunction

  // Adds one destuffed body byte: the byte held back so far is released and
  // the new one takes its place, so the check byte is never passed on.
  function automatic work_t push_byte(input work_t w, input logic [7:0] d);
    work_t o;
    o = w;
    if (w.b.seen != 2'd0) begin
      o.s = append(w.s, data_res(w.b.held));
    end
    o.b.rxor = w.b.rxor ^ d;
    o.b.held = d;
    o.b.seen = (w.b.seen == 2'd2) ? 2'd2 : w.b.seen + 2'd1;
    return o;
  endfunction

endpackage

// ----- rtl/core/sfr_if.sv -----
interface sfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_res_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] data_byte;
  logic [1:0] status;
  logic [7:0] reply_control;
  logic       last;

  modport source (output valid, output out_kind, output data_byte, output status,
                  output reply_control, output last, input ready);
  modport sink (input valid, input out_kind, input data_byte, input status,
                input reply_control, input last, output ready);
endinterface

// ----- rtl/core/stuffed_frame_receiver.sv -----
// Byte-stuffed frame receiver.
//
// Line bytes arrive on the rx channel, one per request. The block hunts for
// the opening flag, checks the station address, the expected sequence
// control byte and the header check byte, and then destuffs the body.
// Results leave on the res channel: payload bytes (out_kind 0) one byte
// late, so that the trailing check byte is never passed on, and one status
// result (out_kind 1) per frame end with the RR or REJ reply control byte
// or per overflow with a zero one; a request's last result carries last.
// A request is decoded in the cycle it is accepted and its results are
// registered in the result queue, behind any results still waiting there.
// One request is taken in every cycle while the queue has room; a request
// may cause two results, and the output port drains one per cycle, so the
// sustained rate is set by that port. A four-entry result queue sits
// between the two sides; rx.ready drops while it could not take two more
// results, so a stalled receiver holds back the line only once the queue
// holds three results. Reset restores the register defaults, clears the
// frame state and empties the queue. Configuration writes are registered;
// the user makes them while the block is idle, which it does not enforce.
module stuffed_frame_receiver (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [sfr_pkg::CFG_W-1:0] cfg_data,
  sfr_rx_if.sink                    rx,
  sfr_res_if.source                 res
);

  logic                        accept;
  sfr_pkg::step_t              step;
  sfr_pkg::result_t            head;
  logic                        head_valid;
  logic                        space;
  logic [sfr_pkg::OUTQ_CW-1:0] fill;

  // A request is taken whenever the queue has room for its worst case.
  assign rx.ready = space;
  assign accept   = rx.valid && space;

  sfr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .rx_byte   (rx.rx_byte),
    .step      (step)
  );

  sfr_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .pop        (res.ready),
    .head_valid (head_valid),
    .head       (head),
    .space      (space),
    .fill       (fill)
  );

  assign res.valid         = head_valid;
  assign res.out_kind      = head.out_kind;
  assign res.data_byte     = head.data_byte;
  assign res.status        = head.status;
  assign res.reply_control = head.reply_control;
  assign res.last          = head.last;

`ifndef ASSERT_OFF
  a_no_result_unless_accept: assert property (@(posedge clk) disable iff (rst)
    !accept |-> step.n == 2'd0)
    else $error("results produced without an accepted request");

  a_last_marks_final: assert property (@(posedge clk) disable iff (rst)
    (step.n == 2'd2) |-> (step.r1.last && !step.r0.last))
    else $error("last not on the final result of a request");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= sfr_pkg::OUTQ_CW'(sfr_pkg::OUTQ_DEPTH))
    else $error("result queue overfilled");

  a_status_after_ready: assert property (@(posedge clk) disable iff (rst)
    (accept && step.n != 2'd0) |=> res.valid)
    else $error("accepted results not visible next cycle");
`endif

endmodule

// ----- rtl/core/sfr_core.sv -----
module sfr_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [sfr_pkg::CFG_W-1:0] cfg_data,
  input  logic                     accept,
  input  logic [7:0]               rx_byte,
  output sfr_pkg::step_t           step
);

  logic [7:0]       station_address;
  logic [11:0]      max_body_bytes;
  sfr_pkg::phase_t  phase;
  sfr_pkg::phase_t  phase_next;
  logic             seq_bit;
  logic             seq_bit_next;
  logic             esc;
  logic             esc_next;
  sfr_pkg::body_t   body;
  sfr_pkg::body_t   body_next;
  logic [11:0]      body_count;
  logic [11:0]      body_count_next;
  sfr_pkg::work_t   w;
  logic [7:0]       ctrl;
  logic [7:0]       r_val;
  logic             overflow;
  logic             good;

  assign ctrl     = seq_bit ? sfr_pkg::CTRL_SEQ1 : sfr_pkg::CTRL_SEQ0;
  assign r_val    = seq_bit ? 8'h00 : sfr_pkg::REPLY_R;
  assign overflow = ({1'b0, body_count} + 13'd1) >= {1'b0, max_body_bytes};

  always_comb begin
    phase_next = sfr_pkg::PH_HUNT;
    case (phase)
      sfr_pkg::PH_ADDR: begin
        if (rx_byte == station_address) phase_next = sfr_pkg::PH_CTRL;
        else if (rx_byte == sfr_pkg::FLAG_BYTE) phase_next = sfr_pkg::PH_ADDR;
      end
      sfr_pkg::PH_CTRL: begin
        if (rx_byte == ctrl) phase_next = sfr_pkg::PH_BCC1;
        else if (rx_byte == sfr_pkg::FLAG_BYTE) phase_next = sfr_pkg::PH_ADDR;
      end
      sfr_pkg::PH_BCC1: begin
        if (rx_byte == (station_address ^ ctrl)) phase_next = sfr_pkg::PH_BODY;
        else if (rx_byte == sfr_pkg::FLAG_BYTE) phase_next = sfr_pkg::PH_ADDR;
      end
      sfr_pkg::PH_BODY: begin
        if (rx_byte != sfr_pkg::FLAG_BYTE && !overflow) phase_next = sfr_pkg::PH_BODY;
      end
      default: begin
        if (rx_byte == sfr_pkg::FLAG_BYTE) phase_next = sfr_pkg::PH_ADDR;
      end
    endcase
  end

  always_comb begin
    w               = '0;
    w.b             = body;
    seq_bit_next    = seq_bit;
    esc_next        = esc;
    body_count_next = body_count;
    good            = 1'b0;
    case (phase)
      sfr_pkg::PH_BCC1: begin
        if (rx_byte == (station_address ^ ctrl)) begin
          esc_next        = 1'b0;
          w.b.seen        = 2'd0;
          w.b.rxor        = 8'h00;
          body_count_next = '0;
        end
      end
      sfr_pkg::PH_BODY: begin
        if (rx_byte == sfr_pkg::FLAG_BYTE) begin
          // A dangling escape before the closing flag is a body byte itself.
          if (esc) w = sfr_pkg::push_byte(w, sfr_pkg::ESC_BYTE);
          esc_next = 1'b0;
          good     = (w.b.seen == 2'd2) && (w.b.rxor == 8'h00);
          if (good) begin
            w.s          = sfr_pkg::append(w.s,
                             sfr_pkg::status_res(sfr_pkg::ST_OK, sfr_pkg::REPLY_RR | r_val));
            seq_bit_next = !seq_bit;
          end else begin
            w.s = sfr_pkg::append(w.s,
                    sfr_pkg::status_res(sfr_pkg::ST_BAD, sfr_pkg::REPLY_REJ | r_val));
          end
        end else if (overflow) begin
          w.s             = sfr_pkg::append(w.s, sfr_pkg::status_res(sfr_pkg::ST_OVF, 8'h00));
          esc_next        = 1'b0;
          w.b.seen        = 2'd0;
          w.b.rxor        = 8'h00;
          body_count_next = '0;
        end else begin
          body_count_next = body_count + 12'd1;
          if (esc) begin
            if (rx_byte == sfr_pkg::ESC_FLAG) begin
              w        = sfr_pkg::push_byte(w, sfr_pkg::FLAG_BYTE);
              esc_next = 1'b0;
            end else if (rx_byte == sfr_pkg::ESC_ESC) begin
              w        = sfr_pkg::push_byte(w, sfr_pkg::ESC_BYTE);
              esc_next = 1'b0;
            end else if (rx_byte == sfr_pkg::ESC_BYTE) begin
              // The first escape passes as data, the second stays pending.
              w = sfr_pkg::push_byte(w, sfr_pkg::ESC_BYTE);
            end else begin
              w        = sfr_pkg::push_byte(w, sfr_pkg::ESC_BYTE);
              w        = sfr_pkg::push_byte(w, rx_byte);
              esc_next = 1'b0;
            end
          end else if (rx_byte == sfr_pkg::ESC_BYTE) begin
            esc_next = 1'b1;
          end else begin
            w = sfr_pkg::push_byte(w, rx_byte);
          end
        end
      end
      default: begin
      end
    endcase
    if (w.s.n == 2'd1) w.s.r0.last = 1'b1;
    if (w.s.n == 2'd2) w.s.r1.last = 1'b1;
    body_next = w.b;
  end

  always_comb begin
    step = w.s;
    if (!accept) step.n = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      station_address <= sfr_pkg::ADDR_RESET;
      max_body_bytes  <= sfr_pkg::MAXB_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sfr_pkg::REG_ADDR: station_address <= cfg_data[7:0];
        sfr_pkg::REG_MAXB: max_body_bytes  <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= sfr_pkg::PH_HUNT;
      seq_bit    <= 1'b0;
      esc        <= 1'b0;
      body       <= '0;
      body_count <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      seq_bit    <= seq_bit_next;
      esc        <= esc_next;
      body       <= body_next;
      body_count <= body_count_next;
    end
  end

endmodule

// ----- rtl/core/sfr_outq.sv -----
module sfr_outq (
  input  logic                        clk,
  input  logic                        rst,
  input  sfr_pkg::step_t              step,
  input  logic                        pop,
  output logic                        head_valid,
  output sfr_pkg::result_t            head,
  output logic                        space,
  output logic [sfr_pkg::OUTQ_CW-1:0] fill
);

  sfr_pkg::result_t              entry [sfr_pkg::OUTQ_DEPTH];
  logic [sfr_pkg::OUTQ_AW-1:0]   wr_ptr;
  logic [sfr_pkg::OUTQ_AW-1:0]   rd_ptr;
  logic                          do_pop;

  assign head_valid = fill != '0;
  assign head       = entry[rd_ptr];
  assign do_pop     = pop && head_valid;
  // Room for the two results one request may cause.
  assign space      = fill <= sfr_pkg::OUTQ_CW'(sfr_pkg::OUTQ_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (step.n != 2'd0) entry[wr_ptr] <= step.r0;
    if (step.n == 2'd2) entry[wr_ptr + sfr_pkg::OUTQ_AW'(1)] <= step.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + sfr_pkg::OUTQ_AW'(step.n);
      if (do_pop) rd_ptr <= rd_ptr + sfr_pkg::OUTQ_AW'(1);
      fill <= fill + sfr_pkg::OUTQ_CW'(step.n) - sfr_pkg::OUTQ_CW'(do_pop);
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
module tb;
  import sfr_pkg::*;

  // Tracks the receiver's frame state from the line bytes it accepts and
  // holds the results those bytes must produce, oldest first.
  class rx_frame_scoreboard;
    logic [7:0]  station_addr;
    logic [11:0] body_limit;
    phase_t      phase;
    bit          seq;
    bit          esc_pending;
    logic [7:0]  held;
    logic [1:0]  seen;
    logic [7:0]  body_xor;
    logic [11:0] body_cnt;
    result_t     step_out[$];
    result_t     pending_results[$];
    int          errors;

    function new();
      station_addr = ADDR_RESET;
      body_limit   = MAXB_RESET;
      phase        = PH_HUNT;
      seq          = 1'b0;
      errors       = 0;
      clear_body();
    endfunction

    function void clear_body();
      esc_pending = 1'b0;
      held        = '0;
      seen        = '0;
      body_xor    = '0;
      body_cnt    = '0;
    endfunction

    function void set_register(logic idx, logic [11:0] value);
      if (idx == REG_ADDR) begin
        station_addr = value[7:0];
      end else begin
        body_limit = value;
      end
    endfunction

    function void emit(logic kind, logic [7:0] data, logic [1:0] st, logic [7:0] reply);
      result_t r;
      r               = '0;
      r.out_kind      = kind;
      r.data_byte     = data;
      r.status        = st;
      r.reply_control = reply;
      step_out.push_back(r);
    endfunction

    // One destuffed body byte: the byte held back is released and the new
    // one is held in its place.
    function void take_body_byte(logic [7:0] d);
      if (seen != 2'd0) begin
        emit(KIND_DATA, held, ST_OK, 8'h00);
      end
      body_xor = body_xor ^ d;
      held     = d;
      if (seen != 2'd2) begin
        seen = seen + 2'd1;
      end
    endfunction

    function void note_request(logic [7:0] b);
      logic [7:0] ctrl;
      logic [7:0] r_bits;
      ctrl   = seq ? CTRL_SEQ1 : CTRL_SEQ0;
      r_bits = seq ? 8'h00 : REPLY_R;
      step_out.delete();
      case (phase)
        PH_ADDR: begin
          if (b == station_addr) begin
            phase = PH_CTRL;
          end else if (b == FLAG_BYTE) begin
            phase = PH_ADDR;
          end else begin
            phase = PH_HUNT;
          end
        end
        PH_CTRL: begin
          if (b == ctrl) begin
            phase = PH_BCC1;
          end else if (b == FLAG_BYTE) begin
            phase = PH_ADDR;
          end else begin
            phase = PH_HUNT;
          end
        end
        PH_BCC1: begin
          if (b == (station_addr ^ ctrl)) begin
            phase = PH_BODY;
            clear_body();
          end else if (b == FLAG_BYTE) begin
            phase = PH_ADDR;
          end else begin
            phase = PH_HUNT;
          end
        end
        PH_BODY: begin
          if (b == FLAG_BYTE) begin
            if (esc_pending) begin
              take_body_byte(ESC_BYTE);
              esc_pending = 1'b0;
            end
            if (seen == 2'd2 && body_xor == 8'h00) begin
              emit(KIND_STATUS, 8'h00, ST_OK, REPLY_RR | r_bits);
              seq = !seq;
            end else begin
              emit(KIND_STATUS, 8'h00, ST_BAD, REPLY_REJ | r_bits);
            end
            phase = PH_HUNT;
          end else if ({1'b0, body_cnt} + 13'd1 >= {1'b0, body_limit}) begin
            emit(KIND_STATUS, 8'h00, ST_OVF, 8'h00);
            phase = PH_HUNT;
            clear_body();
          end else begin
            body_cnt = body_cnt + 12'd1;
            if (esc_pending) begin
              if (b == ESC_FLAG) begin
                take_body_byte(FLAG_BYTE);
                esc_pending = 1'b0;
              end else if (b == ESC_ESC) begin
                take_body_byte(ESC_BYTE);
                esc_pending = 1'b0;
              end else if (b == ESC_BYTE) begin
                take_body_byte(ESC_BYTE);
              end else begin
                take_body_byte(ESC_BYTE);
                take_body_byte(b);
                esc_pending = 1'b0;
              end
            end else if (b == ESC_BYTE) begin
              esc_pending = 1'b1;
            end else begin
              take_body_byte(b);
            end
          end
        end
        default: begin
          if (b == FLAG_BYTE) begin
            phase = PH_ADDR;
          end else begin
            phase = PH_HUNT;
          end
        end
      endcase
      if (step_out.size() > 0) begin
        step_out[step_out.size() - 1].last = 1'b1;
      end
      foreach (step_out[i]) begin
        pending_results.push_back(step_out[i]);
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 25) begin
        $display("MISMATCH: %s", msg);
      end
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result kind=%0d data=%h status=%0d reply=%h last=%0d",
                         got.out_kind, got.data_byte, got.status, got.reply_control,
                         got.last));
      end else begin
        want = pending_results.pop_front();
        if (got.out_kind !== want.out_kind) begin
          report($sformatf("out_kind %0d, expected %0d", got.out_kind, want.out_kind));
        end
        if (got.data_byte !== want.data_byte) begin
          report($sformatf("data_byte %h, expected %h", got.data_byte, want.data_byte));
        end
        if (got.status !== want.status) begin
          report($sformatf("status %0d, expected %0d", got.status, want.status));
        end
        if (got.reply_control !== want.reply_control) begin
          report($sformatf("reply_control %h, expected %h", got.reply_control,
                           want.reply_control));
        end
        if (got.last !== want.last) begin
          report($sformatf("last %0d, expected %0d", got.last, want.last));
        end
      end
    endtask
  endclass

  // Opening stream, sent with the reset register values. The first frame
  // starts with a doubled flag, so the second flag restarts address
  // matching, and its body holds an escaped flag, an escape followed by an
  // escape, and an escape before an ordinary byte; the check byte makes it
  // an accepted frame. The next frame ends on an escape just before the
  // closing flag, and the last one has an empty body: both are too short.
  localparam logic [7:0] DIRECTED [27] = '{
    8'h00, 8'hFF,
    FLAG_BYTE, FLAG_BYTE, ADDR_RESET, CTRL_SEQ0, 8'h03,
    ESC_BYTE, ESC_FLAG, ESC_BYTE, ESC_BYTE, ESC_ESC, ESC_BYTE, 8'h41, 8'h42, FLAG_BYTE,
    FLAG_BYTE, ADDR_RESET, CTRL_SEQ1, 8'h01, ESC_BYTE, FLAG_BYTE,
    FLAG_BYTE, ADDR_RESET, CTRL_SEQ1, 8'h01, FLAG_BYTE
  };

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic                 cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  sfr_rx_if  rx ();
  sfr_res_if res ();

  stuffed_frame_receiver dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (rx),
    .res       (res)
  );

  rx_frame_scoreboard sb;

  // Stall requested of the result side by the stimulus, in cycles.
  int sink_hold = 0;
  // Remaining requests the sender offers back to back with no gaps.
  int src_calm  = 0;
  int items_sent = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The whole run should take well under a tenth of this; reaching it means
  // the block has stopped taking requests or stopped producing results.
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  // Result side. Every result is taken after a random number of idle
  // cycles, apart from occasional runs where ready stays high throughout.
  // A hold requested by the stimulus is served here, counted in cycles, so
  // the block's result queue fills and it has to refuse requests.
  initial begin : result_sink
    int      gap;
    int      calm_left;
    result_t got;
    res.ready <= 1'b0;
    calm_left = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (sink_hold > 0) begin
        gap       = sink_hold;
        sink_hold = 0;
      end else if (calm_left > 0) begin
        gap = 0;
        calm_left--;
      end else begin
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 24) == 0) begin
          calm_left = $urandom_range(20, 60);
        end
      end
      if (gap > 0) begin
        res.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!res.valid);
      got.out_kind      = res.out_kind;
      got.data_byte     = res.data_byte;
      got.status        = res.status;
      got.reply_control = res.reply_control;
      got.last          = res.last;
      sb.check_result(got);
    end
  end

  // Offers one line byte and returns at the edge where it is accepted. The
  // valid stays high on return, so the next call must follow in the same
  // time step: it either lowers valid for a gap or presents the next byte.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (src_calm > 0) begin
      gap = 0;
      src_calm--;
    end else begin
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 24) == 0) begin
        src_calm = $urandom_range(20, 60);
      end
    end
    if (gap > 0) begin
      rx.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk); while (!rx.ready);
    sb.note_request(b);
    items_sent++;
  endtask

  // Stops offering requests until every expected result has been taken.
  // A byte that causes no result may still be in the decoder when the last
  // result leaves, so the task keeps waiting before the block counts as idle.
  task automatic wait_drained();
    rx.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write; the enable is dropped and held low before the task
  // returns, so that back-to-back writes never drive the port twice in one step.
  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_register(idx, value);
    @(posedge clk);
  endtask

  // Body bytes lean towards the flag and escape codes so that stuffing and
  // the escape rules are hit often.
  function automatic logic [7:0] body_byte();
    case ($urandom_range(0, 9))
      0:       return FLAG_BYTE;
      1:       return ESC_BYTE;
      2:       return ESC_FLAG;
      3:       return ESC_ESC;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Sends one frame built for the receiver's present address and sequence
  // bit. Most frames are well formed; the rest carry one defect: a wrong
  // address, control or header check byte, a wrong payload check byte, a
  // stray escape, a missing opening flag, a flag inside the header, or are
  // plain line noise.
  task automatic send_frame();
    logic [7:0] body[$];
    logic [7:0] raw[$];
    logic [7:0] addr_b;
    logic [7:0] ctrl_b;
    logic [7:0] bcc1;
    logic [7:0] chk;
    int         len;
    int         style;
    int         pos;
    style = $urandom_range(0, 99);
    if (style < 8) begin
      repeat ($urandom_range(1, 6)) begin
        send_byte(($urandom_range(0, 3) == 0) ? FLAG_BYTE : 8'($urandom_range(0, 255)));
      end
      return;
    end
    addr_b = sb.station_addr;
    ctrl_b = sb.seq ? CTRL_SEQ1 : CTRL_SEQ0;
    bcc1   = addr_b ^ ctrl_b;
    if (style >= 8 && style < 12) begin
      addr_b = addr_b ^ 8'($urandom_range(1, 255));
    end else if (style >= 12 && style < 16) begin
      ctrl_b = $urandom_range(0, 1) ? (ctrl_b ^ CTRL_SEQ1) : 8'($urandom_range(0, 255));
    end else if (style >= 16 && style < 20) begin
      bcc1 = bcc1 ^ 8'($urandom_range(1, 255));
    end
    len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
    chk = 8'h00;
    repeat (len) begin
      raw.push_back(body_byte());
      chk = chk ^ raw[raw.size() - 1];
    end
    if (style >= 20 && style < 24) begin
      chk = chk ^ 8'($urandom_range(1, 255));
    end
    raw.push_back(chk);
    foreach (raw[i]) begin
      if (raw[i] == FLAG_BYTE) begin
        body.push_back(ESC_BYTE);
        body.push_back(ESC_FLAG);
      end else if (raw[i] == ESC_BYTE) begin
        body.push_back(ESC_BYTE);
        body.push_back(ESC_ESC);
      end else begin
        body.push_back(raw[i]);
      end
    end
    if (style >= 24 && style < 28) begin
      pos = $urandom_range(0, body.size());
      case ($urandom_range(0, 2))
        0: body.push_back(ESC_BYTE);
        1: body.insert(pos, ESC_BYTE);
        default: begin
          body.insert(pos, ESC_BYTE);
          body.insert(pos, ESC_BYTE);
        end
      endcase
    end
    if (style < 28 || style >= 32) begin
      send_byte(FLAG_BYTE);
    end
    if (style >= 36 && $urandom_range(0, 7) == 0) begin
      send_byte(FLAG_BYTE);
    end
    send_byte(addr_b);
    if (style >= 32 && style < 34) begin
      send_byte(FLAG_BYTE);
    end
    send_byte(ctrl_b);
    if (style >= 34 && style < 36) begin
      send_byte(FLAG_BYTE);
    end
    send_byte(bcc1);
    foreach (body[i]) begin
      send_byte(body[i]);
    end
    send_byte(FLAG_BYTE);
  endtask

  task automatic run_frames(input int count);
    int start;
    start = items_sent;
    while (items_sent - start < count) begin
      send_frame();
    end
  endtask

  // Main stimulus: reset, the opening stream with the reset register values,
  // then a series of register settings, each followed by random frames.
  // Every setting is split in two halves with a full drain in between, which
  // leaves the sender silent until the block has nothing left to deliver.
  initial begin : stimulus
    logic [7:0]       addr_plan  [7];
    logic [CFG_W-1:0] limit_plan [7];
    int               count;
    sb = new();
    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_ADDR;
    cfg_data   <= '0;
    rx.valid   <= 1'b0;
    rx.rx_byte <= 8'h00;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      send_byte(DIRECTED[i]);
    end

    // Address extremes, the flag code as an address, and body limits from
    // the two that overflow on the first body byte up to the full range.
    addr_plan[0] = 8'h00;                    limit_plan[0] = 12'd2;
    addr_plan[1] = 8'hFF;                    limit_plan[1] = 12'd4092;
    addr_plan[2] = FLAG_BYTE;                limit_plan[2] = 12'd0;
    addr_plan[3] = 8'($urandom_range(0, 255)); limit_plan[3] = 12'd1;
    addr_plan[4] = 8'($urandom_range(0, 255)); limit_plan[4] = 12'd4095;
    addr_plan[5] = 8'($urandom_range(0, 255));
    limit_plan[5] = 12'($urandom_range(3, 30));
    addr_plan[6] = ADDR_RESET;               limit_plan[6] = MAXB_RESET;

    for (int p = 0; p < 7; p++) begin
      wait_drained();
      // The upper data bits of an address write are random; only the low
      // byte may take effect.
      write_reg(REG_ADDR, {4'($urandom_range(0, 15)), addr_plan[p]});
      write_reg(REG_MAXB, limit_plan[p]);
      count = (limit_plan[p] <= 12'd2) ? 50 : 150;
      // With long frames allowed, hold the result side off for a long
      // stretch while the sender keeps offering requests.
      if (p == 4) begin
        sink_hold = 150;
      end
      run_frames(count / 2);
      wait_drained();
      run_frames(count / 2);
    end

    wait_drained();
    repeat (6) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
